// ----- hw/rtl/lpcald_pkg.sv -----
`timescale 1ns / 1ps

package lpcald_pkg;

    localparam int ORDER_MAX   = 32;
    localparam int FRAME_MAX   = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int E_BITS    = 48;
    localparam int C_BITS    = 32;
    localparam int Q_FRAC    = 20;
    localparam int CFG_BITS  = 6;
    localparam int OUT_IDX_BITS = 6;
    localparam int ST_BITS   = 2;
    localparam int CFG_RESET = 16;

    localparam int IW      = $clog2(ORDER_MAX + 1);
    localparam int FC_BITS = $clog2(FRAME_MAX + 1);
    localparam int P_BITS  = E_BITS + C_BITS - Q_FRAC;
    localparam int MH      = E_BITS / 2;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_EARLY = 2'd1;
    localparam logic [ST_BITS-1:0] ST_ZERO  = 2'd2;
    localparam logic [ST_BITS-1:0] ST_OVF   = 2'd3;

    localparam logic signed [63:0] E_MAX64 = (64'sd1 <<< (E_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] E_MIN64 = -(64'sd1 <<< (E_BITS - 1));
    localparam logic signed [63:0] C_MAX64 = (64'sd1 <<< (C_BITS - 1)) - 64'sd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } in_t;

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] coef_index;
        logic signed [C_BITS-1:0] coefficient;
        logic signed [E_BITS-1:0] gain;
        logic [OUT_IDX_BITS-1:0] order_found;
        logic [ST_BITS-1:0]      status;
        logic                    last_result;
    } out_t;

    typedef struct packed {
        logic shift;
        logic mul;
        logic acc;
        logic xfer;
    } cell_ctrl_t;

    function automatic logic signed [E_BITS-1:0] sat_e(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > E_MAX64) r = E_MAX64;
        if (v < E_MIN64) r = E_MIN64;
        return E_BITS'(r);
    endfunction

    function automatic logic signed [C_BITS-1:0] sat_c(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > C_MAX64) r = C_MAX64;
        if (v < -C_MAX64) r = -C_MAX64;
        return C_BITS'(r);
    endfunction

endpackage

// ----- hw/rtl/lpcald_ram.sv -----
`timescale 1ns / 1ps

module lpcald_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lpcald_cell.sv -----
`timescale 1ns / 1ps

module lpcald_cell (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  lpcald_pkg::cell_ctrl_t                      ctrl,
    input  logic signed [lpcald_pkg::SAMPLE_BITS-1:0]   x,
    input  logic signed [lpcald_pkg::SAMPLE_BITS-1:0]   hist_in,
    output logic signed [lpcald_pkg::SAMPLE_BITS-1:0]   hist_out,
    input  logic signed [lpcald_pkg::E_BITS-1:0]        lag_in,
    output logic signed [lpcald_pkg::E_BITS-1:0]        lag_out
);
    import lpcald_pkg::*;

    logic signed [SAMPLE_BITS-1:0]   hist_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic signed [E_BITS-1:0]        lag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            lag_reg  <= '0;
        end else begin
            if (ctrl.shift) begin
                hist_reg <= hist_in;
            end else if (ctrl.xfer) begin
                hist_reg <= '0;
            end
            if (ctrl.acc) begin
                lag_reg <= sat_e(64'(lag_reg) + 64'(prod_reg));
            end else if (ctrl.xfer) begin
                lag_reg <= lag_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            prod_reg <= x * hist_reg;
        end
    end

    assign hist_out = hist_reg;
    assign lag_out  = lag_reg;

endmodule

// ----- hw/rtl/lpcald_mul.sv -----
`timescale 1ns / 1ps

module lpcald_mul (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [lpcald_pkg::E_BITS-1:0]   a,
    input  logic signed [lpcald_pkg::C_BITS-1:0]   b,
    output logic                                   done,
    output logic signed [lpcald_pkg::P_BITS-1:0]   p
);
    import lpcald_pkg::*;

    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    logic [1:0]             phase_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [E_BITS-1:0]      ua_reg;
    logic [C_BITS-1:0]      ub_reg;
    logic                   neg_reg;
    logic [MH+C_BITS-1:0]   lo_reg;
    logic [MH+C_BITS-1:0]   hi_reg;
    logic signed [P_BITS-1:0] p_reg;

    logic [MH-1:0]          mul_op;
    logic [MH+C_BITS-1:0]   mul_prod;
    logic [E_BITS+C_BITS-1:0] sum;
    logic [P_BITS-1:0]      mag;

    // One multiplier serves both halves of the wide operand.
    assign mul_op   = (phase_reg == PH_LO) ? ua_reg[MH-1:0] : ua_reg[E_BITS-1:MH];
    assign mul_prod = mul_op * ub_reg;
    assign sum      = {hi_reg, {MH{1'b0}}} + {{MH{1'b0}}, lo_reg};
    assign mag      = sum[E_BITS+C_BITS-1:Q_FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LO;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LO;
            end else if (busy_reg) begin
                unique case (phase_reg)
                    PH_LO:  phase_reg <= PH_HI;
                    PH_HI:  phase_reg <= PH_SUM;
                    default: begin
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        phase_reg <= PH_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg  <= a[E_BITS-1] ? E_BITS'(-a) : E_BITS'(a);
            ub_reg  <= b[C_BITS-1] ? C_BITS'(-b) : C_BITS'(b);
            neg_reg <= a[E_BITS-1] ^ b[C_BITS-1];
        end else if (busy_reg) begin
            if (phase_reg == PH_LO) begin
                lo_reg <= mul_prod;
            end else if (phase_reg == PH_HI) begin
                hi_reg <= mul_prod;
            end else begin
                p_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ----- hw/rtl/lpcald_div.sv -----
`timescale 1ns / 1ps

module lpcald_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [lpcald_pkg::E_BITS-1:0]   num,
    input  logic signed [lpcald_pkg::E_BITS-1:0]   den,
    output logic                                   done,
    output logic signed [lpcald_pkg::C_BITS-1:0]   q
);
    import lpcald_pkg::*;

    localparam int SAT_SH = C_BITS - 1 - Q_FRAC;
    localparam int LOW_SH = C_BITS - Q_FRAC;
    localparam int CW     = $clog2(C_BITS);

    logic                   busy_reg;
    logic                   done_reg;
    logic                   pos_reg;
    logic [CW-1:0]          cnt_reg;
    logic [E_BITS-2:0]      ue_reg;
    logic [E_BITS-2:0]      rem_reg;
    logic [C_BITS-1:0]      low_reg;
    logic [C_BITS-1:0]      quo_reg;
    logic signed [C_BITS-1:0] q_reg;

    logic [E_BITS-1:0]      us;
    logic [E_BITS-2:0]      ue;
    logic                   sat;
    logic [E_BITS-1:0]      rem2;
    logic [E_BITS-1:0]      diff;
    logic                   ge;
    logic [C_BITS-1:0]      quo_next;

    assign us  = num[E_BITS-1] ? E_BITS'(-num) : E_BITS'(num);
    assign ue  = den[E_BITS-2:0];
    // An integer quotient of 2048 or more saturates without iterating.
    assign sat = {{SAT_SH{1'b0}}, us} >= {1'b0, ue, {SAT_SH{1'b0}}};

    assign rem2     = {rem_reg, low_reg[C_BITS-1]};
    assign diff     = rem2 - {1'b0, ue_reg};
    assign ge       = rem2 >= {1'b0, ue_reg};
    assign quo_next = {quo_reg[C_BITS-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(C_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            pos_reg <= num[E_BITS-1];
            ue_reg  <= ue;
            rem_reg <= (E_BITS-1)'(us >> LOW_SH);
            low_reg <= {us[LOW_SH-1:0], {Q_FRAC{1'b0}}};
            quo_reg <= '0;
            if (sat) begin
                q_reg <= num[E_BITS-1] ? C_BITS'(C_MAX64) : -C_BITS'(C_MAX64);
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[E_BITS-2:0] : rem2[E_BITS-2:0];
            low_reg <= {low_reg[C_BITS-2:0], 1'b0};
            quo_reg <= quo_next;
            if (cnt_reg == CW'(C_BITS - 1)) begin
                q_reg <= pos_reg ? $signed(quo_next) : -$signed(quo_next);
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ----- hw/rtl/lpc_autocorrelation_levinson_core.sv -----
`timescale 1ns / 1ps

// LPC analysis core: autocorrelation over one frame, then Levinson-Durbin.
// Input channel s_*: one windowed sample per transaction; last_sample ends
// the frame. Each sample is accepted, multiplied in every lag cell and then
// accumulated; s_ready is low meanwhile. Samples past FRAME_MAX are dropped
// and the frame reports status 3.
// After the last sample the lag sums shift out of the cell row into a RAM
// (which also clears the row for the next frame). The recursion then runs
// on one shared multiplier and one bit-serial divider.
// Result channel m_*: one transaction per coefficient 1..m, m set by
// cfg_wr_data (0 acts as 1, above ORDER_MAX acts as ORDER_MAX); each result
// is read from RAM into the result register. A stalled receiver holds the
// result register and the block waits; no new samples are taken until the
// result with last_result has been accepted.
// cfg_wr_en writes the order register, reset value 16. Reset clears the lag
// sums, history, energy and frame counter.

module lpc_autocorrelation_levinson_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lpcald_pkg::CFG_BITS-1:0]   cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lpcald_pkg::in_t                   s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lpcald_pkg::out_t                  m_payload
);
    import lpcald_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MUL      = 5'd1;
    localparam logic [4:0] S_ACC      = 5'd2;
    localparam logic [4:0] S_XFER     = 5'd3;
    localparam logic [4:0] S_INIT     = 5'd4;
    localparam logic [4:0] S_INIT_W   = 5'd5;
    localparam logic [4:0] S_STG      = 5'd6;
    localparam logic [4:0] S_STG_W    = 5'd7;
    localparam logic [4:0] S_DOT_RD   = 5'd8;
    localparam logic [4:0] S_DOT_W    = 5'd9;
    localparam logic [4:0] S_DOT_M    = 5'd10;
    localparam logic [4:0] S_DIV      = 5'd11;
    localparam logic [4:0] S_DIV_W    = 5'd12;
    localparam logic [4:0] S_UPD_RD   = 5'd13;
    localparam logic [4:0] S_UPD_W    = 5'd14;
    localparam logic [4:0] S_UPD_M    = 5'd15;
    localparam logic [4:0] S_UPD_K    = 5'd16;
    localparam logic [4:0] S_EN_M     = 5'd17;
    localparam logic [4:0] S_OUT_RD   = 5'd18;
    localparam logic [4:0] S_OUT_LD   = 5'd19;
    localparam logic [4:0] S_OUT_WAIT = 5'd20;

    localparam int AW_A = IW + 1;

    logic [4:0]               state_reg;
    logic [CFG_BITS-1:0]      cfg_reg;
    logic [FC_BITS-1:0]       fc_reg;
    logic                     ovf_reg;
    logic                     last_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [IW-1:0]            xc_reg;
    logic [IW-1:0]            m_reg;
    logic [IW-1:0]            i_reg;
    logic [IW-1:0]            j_reg;
    logic [IW-1:0]            found_reg;
    logic [ST_BITS-1:0]       status_reg;
    logic                     cur_reg;
    logic signed [E_BITS-1:0] e_reg;
    logic signed [E_BITS-1:0] s_reg;
    logic signed [C_BITS-1:0] k_reg;
    logic signed [C_BITS-1:0] aj_reg;
    logic                     m_valid_reg;
    out_t                     m_payload_reg;

    logic                     s_accept;
    logic                     in_room;
    logic [IW-1:0]            m_eff;
    logic [IW-1:0]            i_m1;
    logic [IW-1:0]            i_mj;
    cell_ctrl_t               cell_ctrl;

    logic signed [SAMPLE_BITS-1:0] hist_chain [0:ORDER_MAX];
    logic signed [E_BITS-1:0]      lag_chain  [0:ORDER_MAX];

    logic [IW-1:0]            lag_raddr;
    logic [E_BITS-1:0]        lag_rdata;
    logic                     a_we;
    logic [AW_A-1:0]          a_waddr;
    logic [C_BITS-1:0]        a_wdata;
    logic [C_BITS-1:0]        a0_rdata;
    logic [C_BITS-1:0]        a1_rdata;

    logic                     mul_start;
    logic signed [E_BITS-1:0] mul_a;
    logic signed [C_BITS-1:0] mul_b;
    logic                     mul_done;
    logic signed [P_BITS-1:0] mul_p;
    logic                     div_done;
    logic signed [C_BITS-1:0] div_q;
    logic signed [E_BITS-1:0] e_new;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign in_room  = fc_reg < FC_BITS'(FRAME_MAX);
    assign i_m1     = i_reg - IW'(1);
    assign i_mj     = i_reg - j_reg;

    always_comb begin
        if (cfg_reg == '0) begin
            m_eff = IW'(1);
        end else if (cfg_reg > CFG_BITS'(ORDER_MAX)) begin
            m_eff = IW'(ORDER_MAX);
        end else begin
            m_eff = IW'(cfg_reg);
        end
    end

    assign cell_ctrl.shift = s_accept && in_room;
    assign cell_ctrl.mul   = (state_reg == S_MUL);
    assign cell_ctrl.acc   = (state_reg == S_ACC);
    assign cell_ctrl.xfer  = (state_reg == S_XFER);

    // Cell k holds x[n-k] and lag sum k; during transfer the sums move one
    // cell toward cell 0, which feeds the lag RAM.
    for (genvar c = 0; c <= ORDER_MAX; c++) begin : g_cell
        lpcald_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .x        (x_reg),
            .hist_in  ((c == 0) ? s_payload.sample : hist_chain[(c == 0) ? 0 : c - 1]),
            .hist_out (hist_chain[c]),
            .lag_in   ((c == ORDER_MAX) ? '0 : lag_chain[(c == ORDER_MAX) ? c : c + 1]),
            .lag_out  (lag_chain[c])
        );
    end

    always_comb begin
        if (state_reg == S_INIT) begin
            lag_raddr = '0;
        end else if (state_reg == S_STG) begin
            lag_raddr = i_reg;
        end else begin
            lag_raddr = i_mj;
        end
    end

    lpcald_ram #(.WIDTH(E_BITS), .DEPTH(ORDER_MAX + 1)) u_lag_ram (
        .aclk  (aclk),
        .we    (state_reg == S_XFER),
        .waddr (xc_reg),
        .wdata (lag_chain[0]),
        .raddr (lag_raddr),
        .rdata (lag_rdata)
    );

    // Predictor work in two banks: a stage reads bank cur and writes the other.
    assign a_we    = ((state_reg == S_UPD_M) && mul_done) || (state_reg == S_UPD_K);
    assign a_waddr = {~cur_reg, (state_reg == S_UPD_K) ? i_reg : j_reg};
    assign a_wdata = (state_reg == S_UPD_K) ? k_reg : sat_c(64'(aj_reg) + 64'(mul_p));

    lpcald_ram #(.WIDTH(C_BITS), .DEPTH(1 << AW_A)) u_a_ram0 (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr ({cur_reg, j_reg}),
        .rdata (a0_rdata)
    );

    lpcald_ram #(.WIDTH(C_BITS), .DEPTH(1 << AW_A)) u_a_ram1 (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr ({cur_reg, i_mj}),
        .rdata (a1_rdata)
    );

    assign mul_start = (state_reg == S_DOT_W) || (state_reg == S_UPD_W) ||
                       (state_reg == S_UPD_K);

    always_comb begin
        if (state_reg == S_DOT_W) begin
            mul_a = $signed(lag_rdata);
            mul_b = $signed(a0_rdata);
        end else if (state_reg == S_UPD_W) begin
            mul_a = E_BITS'(k_reg);
            mul_b = $signed(a1_rdata);
        end else begin
            mul_a = s_reg;
            mul_b = k_reg;
        end
    end

    lpcald_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    lpcald_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_DIV),
        .num     (s_reg),
        .den     (e_reg),
        .done    (div_done),
        .q       (div_q)
    );

    assign e_new = sat_e(64'(e_reg) + 64'(mul_p));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cfg_reg     <= CFG_BITS'(CFG_RESET);
            fc_reg      <= '0;
            ovf_reg     <= 1'b0;
            last_reg    <= 1'b0;
            xc_reg      <= '0;
            m_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            found_reg   <= '0;
            status_reg  <= ST_OK;
            cur_reg     <= 1'b0;
            e_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (in_room) begin
                            fc_reg    <= fc_reg + FC_BITS'(1);
                            last_reg  <= s_payload.last_sample;
                            state_reg <= S_MUL;
                        end else begin
                            ovf_reg <= 1'b1;
                            if (s_payload.last_sample) begin
                                m_reg     <= m_eff;
                                xc_reg    <= '0;
                                fc_reg    <= '0;
                                state_reg <= S_XFER;
                            end
                        end
                    end
                end
                S_MUL: state_reg <= S_ACC;
                S_ACC: begin
                    if (last_reg) begin
                        m_reg     <= m_eff;
                        xc_reg    <= '0;
                        fc_reg    <= '0;
                        state_reg <= S_XFER;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_XFER: begin
                    xc_reg <= xc_reg + IW'(1);
                    if (xc_reg == IW'(ORDER_MAX)) begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT: state_reg <= S_INIT_W;
                S_INIT_W: begin
                    e_reg <= $signed(lag_rdata);
                    if (lag_rdata == '0) begin
                        found_reg  <= '0;
                        status_reg <= ST_ZERO;
                        j_reg      <= IW'(1);
                        state_reg  <= S_OUT_RD;
                    end else begin
                        i_reg     <= IW'(1);
                        state_reg <= S_STG;
                    end
                end
                S_STG: state_reg <= S_STG_W;
                S_STG_W: begin
                    s_reg <= $signed(lag_rdata);
                    j_reg <= IW'(1);
                    state_reg <= (i_reg == IW'(1)) ? S_DIV : S_DOT_RD;
                end
                S_DOT_RD: state_reg <= S_DOT_W;
                S_DOT_W:  state_reg <= S_DOT_M;
                S_DOT_M: begin
                    if (mul_done) begin
                        s_reg <= sat_e(64'(s_reg) + 64'(mul_p));
                        if (j_reg == i_m1) begin
                            state_reg <= S_DIV;
                        end else begin
                            j_reg     <= j_reg + IW'(1);
                            state_reg <= S_DOT_RD;
                        end
                    end
                end
                S_DIV: state_reg <= S_DIV_W;
                S_DIV_W: begin
                    if (div_done) begin
                        k_reg     <= div_q;
                        j_reg     <= IW'(1);
                        state_reg <= (i_reg == IW'(1)) ? S_UPD_K : S_UPD_RD;
                    end
                end
                S_UPD_RD: state_reg <= S_UPD_W;
                S_UPD_W: begin
                    aj_reg    <= $signed(a0_rdata);
                    state_reg <= S_UPD_M;
                end
                S_UPD_M: begin
                    if (mul_done) begin
                        if (j_reg == i_m1) begin
                            state_reg <= S_UPD_K;
                        end else begin
                            j_reg     <= j_reg + IW'(1);
                            state_reg <= S_UPD_RD;
                        end
                    end
                end
                S_UPD_K: state_reg <= S_EN_M;
                S_EN_M: begin
                    if (mul_done) begin
                        e_reg   <= e_new;
                        cur_reg <= ~cur_reg;
                        j_reg   <= IW'(1);
                        // A one-coefficient request that goes non-positive
                        // still counts as full order.
                        if ((e_new[E_BITS-1] || e_new == '0) &&
                            !(i_reg == IW'(1) && m_reg == IW'(1))) begin
                            found_reg  <= (i_reg == IW'(1)) ? IW'(1) : i_m1;
                            status_reg <= ST_EARLY;
                            state_reg  <= S_OUT_RD;
                        end else if (i_reg == m_reg) begin
                            found_reg  <= m_reg;
                            status_reg <= ST_OK;
                            state_reg  <= S_OUT_RD;
                        end else begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= S_STG;
                        end
                    end
                end
                S_OUT_RD: state_reg <= S_OUT_LD;
                S_OUT_LD: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (j_reg == m_reg) begin
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end else begin
                            j_reg     <= j_reg + IW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && in_room) begin
            x_reg <= s_payload.sample;
        end
        if (state_reg == S_OUT_LD) begin
            m_payload_reg.coef_index  <= OUT_IDX_BITS'(j_reg);
            m_payload_reg.coefficient <= (j_reg <= found_reg) ? $signed(a0_rdata) : '0;
            m_payload_reg.gain        <= e_reg;
            m_payload_reg.order_found <= OUT_IDX_BITS'(found_reg);
            m_payload_reg.status      <= ovf_reg ? ST_OVF : status_reg;
            m_payload_reg.last_result <= (j_reg == m_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input accepted while a result is pending");

    a_zero_beyond: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.coef_index > m_payload.order_found)) |->
        (m_payload.coefficient == '0))
        else $error("nonzero coefficient beyond order found");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.last_result) |=> s_ready)
        else $error("not ready after final result");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lpcald_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_BITS-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    in_t s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;

    lpc_autocorrelation_levinson_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Predictor state.
    longint delay_line [ORDER_MAX];
    longint lag_acc [ORDER_MAX+1];
    longint lpc_work [ORDER_MAX+1];
    longint err_energy;
    int accepted_in_frame;
    bit frame_dropped;
    logic [CFG_BITS-1:0] order_reg;

    out_t coef_expect_q[$];
    int errors;
    int cycles;
    bit quiet;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        bit last;
        bit typed;
        longint gain;
        logic [ST_BITS-1:0] st;
    } stim_row_t;

    function automatic longint clamp_energy(longint v);
        if (v > E_MAX64) return E_MAX64;
        if (v < E_MIN64) return E_MIN64;
        return v;
    endfunction

    function automatic longint clamp_coef(longint v);
        if (v > C_MAX64) return C_MAX64;
        if (v < -C_MAX64) return -C_MAX64;
        return v;
    endfunction

    // Full-width product, shifted down 20 bits with truncation toward zero.
    function automatic longint mul_q20(longint x, longint y);
        logic [63:0] ux, uy;
        logic [127:0] p;
        longint mag;
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        p = 128'(ux) * 128'(uy);
        mag = longint'(p >> Q_FRAC);
        return ((x < 0) != (y < 0)) ? -mag : mag;
    endfunction

    function automatic longint reflection(longint s, longint e);
        logic [63:0] us;
        logic [127:0] q;
        us = (s < 0) ? -s : s;
        q = (128'(us) << Q_FRAC) / 128'(e);
        if (q > 128'(C_MAX64)) q = 128'(C_MAX64);
        return (s < 0) ? longint'(q) : -longint'(q);
    endfunction

    function automatic int effective_order(logic [CFG_BITS-1:0] r);
        if (r == 0) return 1;
        if (r > ORDER_MAX) return ORDER_MAX;
        return int'(r);
    endfunction

    function automatic void clear_frame_state();
        for (int k = 0; k < ORDER_MAX; k++) delay_line[k] = 0;
        for (int k = 0; k <= ORDER_MAX; k++) lag_acc[k] = 0;
        accepted_in_frame = 0;
        frame_dropped = 0;
    endfunction

    function automatic void push_frame_results(int m, int found, logic [ST_BITS-1:0] st);
        out_t r;
        for (int j = 1; j <= m; j++) begin
            r.coef_index = OUT_IDX_BITS'(j);
            r.coefficient = (j <= found) ? C_BITS'(lpc_work[j]) : '0;
            r.gain = E_BITS'(err_energy);
            r.order_found = OUT_IDX_BITS'(found);
            r.status = st;
            r.last_result = (j == m);
            coef_expect_q.push_back(r);
        end
    endfunction

    // Autocorrelation update per sample; Levinson-Durbin on the frame's last one.
    function automatic void predict_sample(in_t it);
        longint x, s, kk, t1, t2;
        int m, found;
        logic [ST_BITS-1:0] st;
        x = longint'(it.sample);
        if (accepted_in_frame >= FRAME_MAX) begin
            frame_dropped = 1;
        end else begin
            accepted_in_frame++;
            lag_acc[0] = clamp_energy(lag_acc[0] + x * x);
            for (int k = 1; k <= ORDER_MAX; k++)
                lag_acc[k] = clamp_energy(lag_acc[k] + x * delay_line[k-1]);
            for (int k = ORDER_MAX - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
            delay_line[0] = x;
        end
        if (!it.last_sample) return;

        m = effective_order(order_reg);
        lpc_work[0] = 64'sd1 <<< Q_FRAC;
        if (lag_acc[0] == 0) begin
            found = 0;
            st = ST_ZERO;
            err_energy = 0;
        end else begin
            kk = reflection(lag_acc[1], lag_acc[0]);
            lpc_work[1] = kk;
            err_energy = clamp_energy(lag_acc[0] + mul_q20(lag_acc[1], kk));
            found = m;
            st = ST_OK;
            if (err_energy <= 0 && m > 1) begin
                found = 1;
                st = ST_EARLY;
            end else begin
                for (int i = 2; i <= m; i++) begin
                    s = lag_acc[i];
                    for (int j = 1; j < i; j++)
                        s = clamp_energy(s + mul_q20(lag_acc[i-j], lpc_work[j]));
                    kk = reflection(s, err_energy);
                    for (int j = 1; j <= i / 2; j++) begin
                        t1 = clamp_coef(lpc_work[j] + mul_q20(kk, lpc_work[i-j]));
                        t2 = clamp_coef(lpc_work[i-j] + mul_q20(kk, lpc_work[j]));
                        lpc_work[j] = t1;
                        lpc_work[i-j] = t2;
                    end
                    lpc_work[i] = kk;
                    err_energy = clamp_energy(err_energy + mul_q20(s, kk));
                    if (err_energy <= 0) begin
                        found = i - 1;
                        st = ST_EARLY;
                        break;
                    end
                end
            end
        end
        if (frame_dropped) st = ST_OVF;
        push_frame_results(m, found, st);
        clear_frame_state();
    endfunction

    // Sends one sample; the caller decides how its results are predicted.
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, bit last);
        while (!quiet && $urandom_range(99) < 11) @(negedge aclk);
        s_valid = 1'b1;
        s_payload.sample = smp;
        s_payload.last_sample = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_order(logic [CFG_BITS-1:0] v);
        wait (coef_expect_q.size() == 0);
        repeat (20) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        order_reg = v;
    endtask

    task automatic send_frame(int len, int kind);
        logic signed [SAMPLE_BITS-1:0] smp;
        int level;
        in_t it;
        level = $urandom_range(65535) - 32768;
        for (int n = 0; n < len; n++) begin
            case (kind)
                0: smp = SAMPLE_BITS'($urandom);
                1: smp = SAMPLE_BITS'(level);
                2: smp = SAMPLE_BITS'(((n % 8) < 4 ? 1 : -1) * (level / 2)
                                      + int'($urandom_range(63)) - 32);
                3: smp = '0;
                default: smp = SAMPLE_BITS'(int'($urandom_range(255)) - 128);
            endcase
            it.sample = smp;
            it.last_sample = (n == len - 1);
            send_sample(smp, it.last_sample);
            predict_sample(it);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (coef_expect_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, m_payload);
                errors <= errors + 1;
            end else begin
                want = coef_expect_q.pop_front();
                if (want !== m_payload) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, m_payload);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end

    initial begin
        stim_row_t rows [$];
        in_t it;
        out_t r;
        int m, sent, ph;
        logic [CFG_BITS-1:0] order_plan [$];

        errors = 0;
        cycles = 0;
        quiet = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        order_reg = CFG_BITS'(CFG_RESET);
        for (int k = 0; k <= ORDER_MAX; k++) lpc_work[k] = 0;
        err_energy = 0;
        clear_frame_state();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Single-sample frames have zero lag-1 sum, so every coefficient is 0
        // and the gain equals the sample squared; an all-zero frame has no energy.
        rows.push_back('{16'sd0, 1, 1, 0, ST_ZERO});
        rows.push_back('{-16'sd32768, 1, 1, 64'd1073741824, ST_OK});
        rows.push_back('{16'sd32767, 1, 1, 64'd1073676289, ST_OK});
        rows.push_back('{16'sd1, 1, 1, 1, ST_OK});
        rows.push_back('{16'sd32767, 0, 0, 0, ST_OK});
        rows.push_back('{-16'sd32768, 0, 0, 0, ST_OK});
        rows.push_back('{16'sd32767, 0, 0, 0, ST_OK});
        rows.push_back('{-16'sd32768, 1, 0, 0, ST_OK});
        for (int n = 0; n < 6; n++) rows.push_back('{16'sd1000, n == 5, 0, 0, ST_OK});
        for (int n = 0; n < 3; n++) rows.push_back('{16'sd0, n == 2, 1, 0, ST_ZERO});
        rows.push_back('{16'sd5, 0, 0, 0, ST_OK});
        rows.push_back('{-16'sd3, 0, 0, 0, ST_OK});
        rows.push_back('{16'sd2, 1, 0, 0, ST_OK});

        foreach (rows[i]) begin
            it.sample = rows[i].smp;
            it.last_sample = rows[i].last;
            send_sample(it.sample, it.last_sample);
            if (rows[i].typed) begin
                if (it.last_sample) begin
                    m = effective_order(order_reg);
                    for (int j = 1; j <= m; j++) begin
                        r.coef_index = OUT_IDX_BITS'(j);
                        r.coefficient = '0;
                        r.gain = E_BITS'(rows[i].gain);
                        r.order_found = (rows[i].st == ST_ZERO) ? '0 : OUT_IDX_BITS'(m);
                        r.status = rows[i].st;
                        r.last_result = (j == m);
                        coef_expect_q.push_back(r);
                    end
                    clear_frame_state();
                end
            end else begin
                predict_sample(it);
            end
        end

        order_plan = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd33, 6'd16, 6'd8};
        sent = 0;
        ph = 0;
        while (sent < 400) begin
            write_order(ph < order_plan.size() ? order_plan[ph] : CFG_BITS'($urandom));
            quiet = (sent > 150 && sent < 250);
            if (ph == 3) begin
                // Frame longer than capacity: the tail is dropped.
                send_frame(FRAME_MAX + 6, 0);
            end
            for (int f = 0; f < 5; f++) begin
                m = $urandom_range(1, 30);
                send_frame(m, $urandom_range(5));
                sent += m;
            end
            ph++;
        end
        quiet = 0;

        wait (coef_expect_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
